/* rtl/look_disk_request_scheduler_defines.svh */
// Assertion helpers used by look_disk_request_scheduler.sv.
`ifndef LOOK_DISK_REQUEST_SCHEDULER_DEFINES_SVH
`define LOOK_DISK_REQUEST_SCHEDULER_DEFINES_SVH

// Same-cycle implication.
`define LDRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LDRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ldrs_pkg.sv */
`timescale 1ns / 1ps

package ldrs_pkg;

    localparam int MAX_REQUESTS = 64;
    localparam int TRACK_BITS   = 16;
    localparam int ADDR_W       = $clog2(MAX_REQUESTS);
    localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
    localparam int MOVE_W       = 22;
    localparam int CFG_IDX_W    = 2;

    typedef logic [TRACK_BITS-1:0] track_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [MOVE_W-1:0]     move_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

    localparam cfg_idx_t CFG_START_TRACK = 2'd0;
    localparam cfg_idx_t CFG_SWEEP_UP    = 2'd1;

    localparam cnt_t  CNT_MAX  = CNT_W'(MAX_REQUESTS);
    localparam move_t MOVE_MAX = {MOVE_W{1'b1}};

endpackage

/* rtl/ldrs_req_if.sv */
`timescale 1ns / 1ps

interface ldrs_req_if;
    import ldrs_pkg::*;

    logic   valid;
    logic   ready;
    track_t request_track;
    logic   batch_end;

    modport source (output valid, output request_track, output batch_end, input ready);
    modport sink   (input valid, input request_track, input batch_end, output ready);
endinterface

/* rtl/ldrs_res_if.sv */
`timescale 1ns / 1ps

interface ldrs_res_if;
    import ldrs_pkg::*;

    logic   valid;
    logic   ready;
    track_t served_track;
    move_t  total_movement;
    logic   empty_batch;
    logic   final_result;

    modport source (output valid, output served_track, output total_movement,
                    output empty_batch, output final_result, input ready);
    modport sink   (input valid, input served_track, input total_movement,
                    input empty_batch, input final_result, output ready);
endinterface

/* rtl/ldrs_cfg_if.sv */
`timescale 1ns / 1ps

interface ldrs_cfg_if;
    import ldrs_pkg::*;

    logic     valid;
    logic     ready;
    cfg_idx_t index;
    track_t   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/ldrs_ram.sv */
`timescale 1ns / 1ps

module ldrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/look_disk_request_scheduler.sv */
`timescale 1ns / 1ps
// Channel  Dir  Payload                                              Beat when
// req      in   request_track[15:0], batch_end                       valid & ready
// res      out  served_track[15:0], total_movement[21:0],
//               empty_batch, final_result                            valid & ready
// cfg      in   index[1:0] (0 start_track, 1 sweep_up), data[15:0]   valid & ready
//
// A request is kept sorted in the store on arrival: insertion walks down from
// the top entry, one RAM read/compare/write per cycle. The batch end adds a scan
// of the store to locate the head, then one RAM read per result (S_ERD, then
// S_EDAT) plus any output stall.
// Reset clears count, config and the output register; store contents are
// don't-care. cfg is always ready; res stalls hold the scheduler in place.

`include "look_disk_request_scheduler_defines.svh"

module look_disk_request_scheduler (
    input  logic clk,
    input  logic rst_n,
    ldrs_req_if.sink   req,
    ldrs_res_if.source res,
    ldrs_cfg_if.sink   cfg
);
    import ldrs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_SCAN,
        S_ERD,
        S_EDAT,
        S_EMPTY
    } state_t;

    state_t state_reg;
    cnt_t   count_reg;
    track_t ins_track_reg;
    addr_t  ins_j_reg;
    logic   end_pending_reg;
    track_t start_track_reg;
    logic   sweep_up_reg;
    logic   up_reg;
    track_t head_reg;
    cnt_t   scan_idx_reg;
    logic   scan_vld_reg;
    cnt_t   less_reg;
    cnt_t   le_reg;
    cnt_t   k_reg;
    move_t  move_reg;

    logic   out_valid_reg;
    track_t out_track_reg;
    move_t  out_move_reg;
    logic   out_empty_reg;
    logic   out_final_reg;

    logic   ram_we;
    addr_t  ram_waddr;
    track_t ram_wdata;
    addr_t  ram_raddr;
    track_t ram_rdata;

    logic   req_beat;
    logic   out_free;
    cnt_t   n_hi;
    cnt_t   served;
    cnt_t   emit_idx;
    track_t head_gap;
    logic [MOVE_W:0] move_sum;
    move_t  move_next;
    logic   last_emit;

    ldrs_ram #(
        .WIDTH (TRACK_BITS),
        .DEPTH (MAX_REQUESTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_beat  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign res.valid          = out_valid_reg;
    assign res.served_track   = out_track_reg;
    assign res.total_movement = out_move_reg;
    assign res.empty_batch    = out_empty_reg;
    assign res.final_result   = out_final_reg;

    assign out_free = !out_valid_reg || res.ready;

    // Sorted store: [0, less) below head, [less, le) at head, [le, count) above.
    assign n_hi   = count_reg - le_reg;
    assign served = less_reg + n_hi;

    always_comb
    begin
        if (up_reg)
        begin
            if (k_reg < n_hi)
                emit_idx = le_reg + k_reg;
            else
                emit_idx = less_reg - 1'b1 - (k_reg - n_hi);
        end
        else
        begin
            if (k_reg < less_reg)
                emit_idx = less_reg - 1'b1 - k_reg;
            else
                emit_idx = le_reg + (k_reg - less_reg);
        end
    end

    assign head_gap  = (ram_rdata > head_reg) ? ram_rdata - head_reg : head_reg - ram_rdata;
    assign move_sum  = {1'b0, move_reg} + (MOVE_W + 1)'(head_gap);
    assign move_next = move_sum[MOVE_W] ? MOVE_MAX : move_sum[MOVE_W-1:0];
    assign last_emit = (k_reg == served - 1'b1);

    always_comb
    begin
        ram_raddr = '0;
        case (state_reg)
            S_IDLE:          ram_raddr = ADDR_W'(count_reg - 1'b1);
            S_INS:           ram_raddr = ins_j_reg - ADDR_W'(2);
            S_SCAN:          ram_raddr = scan_idx_reg[ADDR_W-1:0];
            S_ERD, S_EDAT:   ram_raddr = emit_idx[ADDR_W-1:0];
            default:         ram_raddr = '0;
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = ins_track_reg;
        case (state_reg)
            S_IDLE:
            begin
                ram_we    = req_beat && (count_reg == '0);
                ram_wdata = req.request_track;
            end
            S_INS:
            begin
                ram_we    = 1'b1;
                ram_waddr = ins_j_reg;
                ram_wdata = (ram_rdata > ins_track_reg) ? ram_rdata : ins_track_reg;
            end
            S_PUT:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_track_reg <= '0;
            sweep_up_reg    <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_START_TRACK: start_track_reg <= cfg.data;
                CFG_SWEEP_UP:    sweep_up_reg    <= cfg.data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            end_pending_reg <= 1'b0;
            scan_vld_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            ins_track_reg   <= '0;
            ins_j_reg       <= '0;
            up_reg          <= 1'b0;
            head_reg        <= '0;
            scan_idx_reg    <= '0;
            less_reg        <= '0;
            le_reg          <= '0;
            k_reg           <= '0;
            move_reg        <= '0;
            out_track_reg   <= '0;
            out_move_reg    <= '0;
            out_empty_reg   <= 1'b0;
            out_final_reg   <= 1'b0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req_beat)
                    begin
                        end_pending_reg <= req.batch_end;
                        ins_track_reg   <= req.request_track;
                        if ((count_reg < CNT_MAX) && (count_reg != '0))
                        begin
                            count_reg <= count_reg + 1'b1;
                            ins_j_reg <= count_reg[ADDR_W-1:0];
                            state_reg <= S_INS;
                        end
                        else
                        begin
                            if (count_reg == '0)
                                count_reg <= count_reg + 1'b1;
                            if (req.batch_end)
                            begin
                                state_reg    <= S_SCAN;
                                scan_idx_reg <= '0;
                                scan_vld_reg <= 1'b0;
                                less_reg     <= '0;
                                le_reg       <= '0;
                            end
                        end
                    end
                end

                S_INS, S_PUT:
                begin
                    if ((state_reg == S_INS) && (ram_rdata > ins_track_reg))
                    begin
                        ins_j_reg <= ins_j_reg - 1'b1;
                        if (ins_j_reg == ADDR_W'(1))
                            state_reg <= S_PUT;
                    end
                    else if (end_pending_reg)
                    begin
                        state_reg    <= S_SCAN;
                        scan_idx_reg <= '0;
                        scan_vld_reg <= 1'b0;
                        less_reg     <= '0;
                        le_reg       <= '0;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_SCAN:
                begin
                    if (scan_vld_reg)
                    begin
                        if (ram_rdata < start_track_reg)
                            less_reg <= less_reg + 1'b1;
                        if (ram_rdata <= start_track_reg)
                            le_reg <= le_reg + 1'b1;
                    end
                    if (scan_idx_reg < count_reg)
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                        scan_vld_reg <= 1'b1;
                    end
                    else
                    begin
                        scan_vld_reg <= 1'b0;
                        if (!scan_vld_reg)
                        begin
                            head_reg  <= start_track_reg;
                            up_reg    <= sweep_up_reg;
                            move_reg  <= '0;
                            k_reg     <= '0;
                            state_reg <= (served == '0) ? S_EMPTY : S_ERD;
                        end
                    end
                end

                S_ERD:
                begin
                    state_reg <= S_EDAT;
                end

                S_EDAT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_track_reg <= ram_rdata;
                        out_move_reg  <= move_next;
                        out_empty_reg <= 1'b0;
                        out_final_reg <= last_emit;
                        move_reg      <= move_next;
                        head_reg      <= ram_rdata;
                        k_reg         <= k_reg + 1'b1;
                        if (last_emit)
                        begin
                            count_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_ERD;
                        end
                    end
                end

                S_EMPTY:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_track_reg <= '0;
                        out_move_reg  <= '0;
                        out_empty_reg <= 1'b1;
                        out_final_reg <= 1'b1;
                        count_reg     <= '0;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `LDRS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_MAX,
        "store count overflow")
    `LDRS_ASSERT_NOW(a_split_order, clk, rst_n,
        (state_reg == S_ERD) || (state_reg == S_EMPTY),
        (less_reg <= le_reg) && (le_reg <= count_reg), "head split out of order")
    `LDRS_ASSERT_NOW(a_empty_beat, clk, rst_n, out_valid_reg && out_empty_reg,
        out_final_reg && (out_track_reg == '0) && (out_move_reg == '0),
        "malformed empty beat")
    `LDRS_ASSERT_NEXT(a_final_clears, clk, rst_n,
        (state_reg == S_EDAT) && out_free && last_emit,
        (count_reg == '0) && (state_reg == S_IDLE), "store not released after final beat")

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import ldrs_pkg::*;

    localparam int       WATCHDOG_LIMIT = 4000;
    localparam int       LONG_HOLD      = 400;
    localparam int       SETTLE_CYCLES  = 2 * MAX_REQUESTS + 8;
    localparam int       MAX_PRINTS     = 40;
    localparam cfg_idx_t CFG_SPARE_2    = 2'd2;
    localparam cfg_idx_t CFG_SPARE_3    = 2'd3;

    typedef struct {
        track_t track;
        logic   last;
    } req_beat_t;

    typedef struct {
        track_t track;
        move_t  moved;
        logic   empty;
        logic   last;
    } served_t;

    logic clk;
    logic rst_n;

    ldrs_req_if req ();
    ldrs_res_if res ();
    ldrs_cfg_if cfg ();

    look_disk_request_scheduler u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res),
        .cfg   (cfg)
    );

    // testbench copy of the block state
    track_t    req_store [MAX_REQUESTS];
    int        req_count;
    track_t    head_cfg;
    logic      sweep_cfg;

    req_beat_t req_queue [$];
    served_t   served_expect [$];
    served_t   want;

    int        err_cnt;
    int        send_wait;
    int        recv_wait;
    int        recv_hold;
    int        send_gap_max;
    int        recv_gap_max;
    bit        long_hold_go;
    bit        long_hold_seen;
    int        quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Insert into the sorted store; on batch end build the LOOK route.
    function automatic void record_request(track_t t, logic last);
        track_t  route [$];
        int      j;
        int      n_low;
        longint  moved;
        track_t  pos;
        served_t r;
        if (req_count < MAX_REQUESTS)
        begin
            j = req_count;
            while (j > 0 && req_store[j-1] > t)
            begin
                req_store[j] = req_store[j-1];
                j--;
            end
            req_store[j] = t;
            req_count++;
        end
        if (!last)
            return;
        n_low = 0;
        for (int i = 0; i < req_count; i++)
            if (req_store[i] < head_cfg)
                n_low++;
        if (sweep_cfg)
        begin
            for (int i = 0; i < req_count; i++)
                if (req_store[i] > head_cfg)
                    route.push_back(req_store[i]);
            for (int i = n_low - 1; i >= 0; i--)
                route.push_back(req_store[i]);
        end
        else
        begin
            for (int i = n_low - 1; i >= 0; i--)
                route.push_back(req_store[i]);
            for (int i = 0; i < req_count; i++)
                if (req_store[i] > head_cfg)
                    route.push_back(req_store[i]);
        end
        req_count = 0;
        if (route.size() == 0)
        begin
            r.track = '0;
            r.moved = '0;
            r.empty = 1'b1;
            r.last  = 1'b1;
            served_expect.push_back(r);
            return;
        end
        pos   = head_cfg;
        moved = 0;
        for (int i = 0; i < route.size(); i++)
        begin
            moved += longint'((route[i] > pos) ? route[i] - pos : pos - route[i]);
            if (moved > MOVE_MAX)
                moved = longint'(MOVE_MAX);
            pos     = route[i];
            r.track = route[i];
            r.moved = move_t'(moved);
            r.empty = 1'b0;
            r.last  = (i == route.size() - 1);
            served_expect.push_back(r);
        end
    endfunction

    function automatic void check_field(string name, longint unsigned want_v,
                                        longint unsigned got_v);
        if (want_v != got_v)
        begin
            err_cnt++;
            if (err_cnt <= MAX_PRINTS)
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, name, want_v, got_v);
        end
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req.valid         <= 1'b0;
            req.request_track <= '0;
            req.batch_end     <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                record_request(req.request_track, req.batch_end);
                send_wait = $urandom_range(0, send_gap_max);
            end
            if (!req.valid || req.ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    req.valid <= 1'b0;
                end
                else if (req_queue.size() > 0)
                begin
                    req.valid         <= 1'b1;
                    req.request_track <= req_queue[0].track;
                    req.batch_end     <= req_queue[0].last;
                    req_queue.pop_front();
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // result monitor and ready generator
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            recv_wait = 0;
            recv_hold = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (served_expect.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_PRINTS)
                        $display("%0t: unexpected result: expected none, actual track %0d move %0d",
                                 $time, res.served_track, res.total_movement);
                end
                else
                begin
                    want = served_expect.pop_front();
                    check_field("served_track", 64'(want.track), 64'(res.served_track));
                    check_field("total_movement", 64'(want.moved), 64'(res.total_movement));
                    check_field("empty_batch", 64'(want.empty), 64'(res.empty_batch));
                    check_field("final_result", 64'(want.last), 64'(res.final_result));
                end
                recv_wait = $urandom_range(0, recv_gap_max);
            end
            if (long_hold_go && !long_hold_seen)
            begin
                long_hold_seen = 1'b1;
                recv_hold      = LONG_HOLD;
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                res.ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                res.ready <= 1'b0;
            end
            else
                res.ready <= 1'b1;
        end
    end

    // watchdog: cycles without any beat on any channel
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((req.valid && req.ready) || (res.valid && res.ready) ||
                 (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, served_expect.size());
            $display("** look_disk_request_scheduler: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic cfg_write(input cfg_idx_t idx, input track_t data);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == CFG_START_TRACK)
            head_cfg = data;
        else if (idx == CFG_SWEEP_UP)
            sweep_cfg = data[0];
    endtask

    task automatic set_head(input track_t start, input logic up);
        track_t d;
        cfg_write(CFG_START_TRACK, start);
        d    = track_t'($urandom);
        d[0] = up;
        cfg_write(CFG_SWEEP_UP, d);
        @(negedge clk);
    endtask

    task automatic push_req(input track_t t, input logic last);
        req_beat_t b;
        b.track = t;
        b.last  = last;
        req_queue.push_back(b);
    endtask

    function automatic track_t pick_track(track_t head);
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return head;
            1:       return '0;
            2:       return '1;
            3, 4:    return head + track_t'($urandom_range(0, 16)) - track_t'(8);
            default: return track_t'($urandom);
        endcase
    endfunction

    task automatic queue_batch(input int n);
        for (int i = 0; i < n; i++)
            push_req(pick_track(head_cfg), i == n - 1);
    endtask

    // sender stays quiet until the block has drained
    task automatic wait_idle();
        do
            @(negedge clk);
        while (req_queue.size() != 0 || req.valid || served_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int     sent;
        int     n;
        track_t st;
        logic   up;
        rst_n             = 1'b0;
        cfg.valid         = 1'b0;
        cfg.index         = CFG_START_TRACK;
        cfg.data          = '0;
        head_cfg          = '0;
        sweep_cfg         = 1'b0;
        send_gap_max      = 8;
        recv_gap_max      = 8;
        long_hold_go      = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset config: request at the head alone, then only head requests
        push_req(16'h0000, 1'b1);
        push_req(16'h0000, 1'b0);
        push_req(16'h0000, 1'b1);
        wait_idle();

        // spare indexes must leave the config untouched
        cfg_write(CFG_SPARE_2, 16'hFFFF);
        cfg_write(CFG_SPARE_3, 16'h5A5A);
        set_head(16'h8000, 1'b1);
        push_req(16'hFFFF, 1'b0);
        push_req(16'h0000, 1'b0);
        push_req(16'h8000, 1'b0);
        push_req(16'h8001, 1'b0);
        push_req(16'h7FFF, 1'b0);
        push_req(16'h8001, 1'b0);
        push_req(16'h1234, 1'b1);
        wait_idle();

        set_head(16'hFFFF, 1'b0);
        push_req(16'h0000, 1'b0);
        push_req(16'hFFFF, 1'b0);
        push_req(16'h7FFF, 1'b1);
        wait_idle();

        // nothing on the first side: reverse straight away
        set_head(16'h0000, 1'b0);
        push_req(16'h0003, 1'b0);
        push_req(16'h0005, 1'b0);
        push_req(16'h0001, 1'b1);
        wait_idle();

        set_head(16'hFFFF, 1'b1);
        push_req(16'hFFFE, 1'b0);
        push_req(16'h0002, 1'b1);
        push_req(16'h4321, 1'b1);
        wait_idle();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       begin st = 16'h0000; up = 1'b0; end
                1:       begin st = 16'hFFFF; up = 1'b1; end
                2:       begin st = 16'hFFFF; up = 1'b0; end
                3:       begin st = 16'h0000; up = 1'b1; end
                default: begin st = track_t'($urandom); up = 1'($urandom_range(0, 1)); end
            endcase
            set_head(st, up);
            if (phase % 3 == 0)
            begin
                send_gap_max = 0;
                recv_gap_max = 0;
            end
            else if (phase == 4)
            begin
                send_gap_max = 0;
                recv_gap_max = 8;
            end
            else
            begin
                send_gap_max = 8;
                recv_gap_max = (phase == 7) ? 0 : 8;
            end
            if (phase == 5)
            begin
                // overfull batch: the tail tracks are discarded, but its batch end still closes the batch
                queue_batch(MAX_REQUESTS + 2);
                queue_batch($urandom_range(1, 4));
            end
            else
            begin
                sent = 0;
                while (sent < 22)
                begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20)
                                                    : $urandom_range(1, 6);
                    queue_batch(n);
                    sent += n;
                end
            end
            if (phase == 4)
                long_hold_go = 1'b1;
            wait_idle();
        end

        if (err_cnt == 0 && served_expect.size() == 0)
            $display("** look_disk_request_scheduler: PASSED **");
        else
            $display("** look_disk_request_scheduler: FAILED **");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/ldrs_pkg.sv
rtl/ldrs_req_if.sv
rtl/ldrs_res_if.sv
rtl/ldrs_cfg_if.sv
rtl/ldrs_ram.sv
rtl/look_disk_request_scheduler.sv
sim/testbench.sv
